// File: rtl/fpts_pkg.sv
// Shared types and constants for the fixed-priority task selector.
package fpts_pkg;

  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_WAIT     = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;
  localparam logic [1:0] OP_SCHEDULE = 2'd3;

  localparam logic [7:0] LIMIT_RESET = 8'd10;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] task_priority;
    logic [7:0] task_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] selected_slot;
    logic [7:0] selected_id;
    logic       selected_ready;
    logic       status;
  } out_word_t;

  typedef struct packed {
    logic       wr_en;
    logic       clr_en;
    logic       start_en;
    logic [7:0] wr_prio;
    logic [7:0] wr_id;
    logic [7:0] start_id;
  } cell_ctl_t;

  typedef struct packed {
    logic       tok;
    logic       found;
    logic [7:0] best;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fpts_state_t;

endpackage

// File: rtl/fpts_cell.sv
// One task slot of the selector chain, with its stage of the selection scan.
module fpts_cell #(
  parameter int IDXW = 3,
  parameter int IDX  = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpts_pkg::cell_ctl_t ctl_i,
  input  fpts_pkg::scan_t     scan_i,
  input  logic [IDXW-1:0]     sel_i,
  output fpts_pkg::scan_t     scan_o,
  output logic [IDXW-1:0]     sel_o,
  output logic [7:0]          id_o,
  output logic                ready_o
);
  import fpts_pkg::*;

  logic            used_r;
  logic            ready_r;
  logic [7:0]      prio_r;
  logic [7:0]      id_r;
  scan_t           scan_r;
  scan_t           scan_nxt;
  logic [IDXW-1:0] sel_r;
  logic [IDXW-1:0] sel_nxt;
  logic            qualify;

  always_comb begin
    qualify        = scan_i.tok && used_r && ready_r && (prio_r <= scan_i.best);
    scan_nxt.tok   = scan_i.tok;
    scan_nxt.found = scan_i.found | qualify;
    scan_nxt.best  = qualify ? prio_r : scan_i.best;
    sel_nxt        = qualify ? IDXW'(IDX) : sel_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      ready_r <= 1'b0;
      prio_r  <= '0;
      id_r    <= '0;
      scan_r  <= '0;
      sel_r   <= '0;
    end else begin
      if (ctl_i.wr_en) begin
        used_r  <= 1'b1;
        ready_r <= 1'b1;
        prio_r  <= ctl_i.wr_prio;
        id_r    <= ctl_i.wr_id;
      end else if (ctl_i.clr_en) begin
        ready_r <= 1'b0;
      end else if (ctl_i.start_en && used_r && (id_r == ctl_i.start_id)) begin
        ready_r <= 1'b1;
      end
      scan_r <= scan_nxt;
      sel_r  <= sel_nxt;
    end
  end

  assign scan_o  = scan_r;
  assign sel_o   = sel_r;
  assign id_o    = id_r;
  assign ready_o = ready_r;

endmodule

// File: rtl/fixed_priority_task_selector.sv
// Top level of the fixed-priority task selector: controller and chain of slot cells.
// A create or start word goes from acceptance to the done state and then into the output register
// when the output is not stalled. A wait or schedule word first launches the selection scan, which
// travels down the chain of slot cells one cell per clock; the selection is updated, if a cell
// qualified, as the scan leaves the last cell, and the result is then loaded into the output register.
// A new word is accepted only after the previous result has been loaded into the output register,
// so a stalled output also holds off new words.
module fixed_priority_task_selector #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output fpts_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import fpts_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  fpts_state_t     state_r;
  fpts_state_t     state_nxt;
  logic            start_r;
  logic            status_r;
  logic [CNTW-1:0] count_r;
  logic [IDXW-1:0] chosen_r;
  logic [7:0]      limit_r;
  logic            out_valid_r;
  out_word_t       out_word_r;

  logic            in_accept;
  logic            launch;
  logic            load_out;
  logic            scan_end;
  logic            is_create;
  logic            is_wait;
  logic            is_start;
  logic            table_full;

  cell_ctl_t       ctl      [SLOTS];
  scan_t           chain    [SLOTS+1];
  logic [IDXW-1:0] sel_chain[SLOTS+1];
  logic [7:0]      cell_id  [SLOTS];
  logic            cell_rdy [SLOTS];
  logic [IDXW+2:0] chosen_ext;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign is_create  = (in_word.opcode == OP_CREATE);
  assign is_wait    = (in_word.opcode == OP_WAIT);
  assign is_start   = (in_word.opcode == OP_START);
  assign table_full = (count_r == CNTW'(SLOTS));
  assign scan_end   = chain[SLOTS].tok;

  assign chain[0].tok   = start_r;
  assign chain[0].found = 1'b0;
  assign chain[0].best  = limit_r;
  assign sel_chain[0]   = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      ctl[i].wr_en    = in_accept && is_create && (count_r == CNTW'(i));
      ctl[i].clr_en   = in_accept && is_wait && (chosen_r == IDXW'(i));
      ctl[i].start_en = in_accept && is_start;
      ctl[i].wr_prio  = in_word.task_priority;
      ctl[i].wr_id    = in_word.task_id;
      ctl[i].start_id = in_word.task_id;
    end

    fpts_cell #(
      .IDXW (IDXW),
      .IDX  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[i]),
      .scan_i  (chain[i]),
      .sel_i   (sel_chain[i]),
      .scan_o  (chain[i+1]),
      .sel_o   (sel_chain[i+1]),
      .id_o    (cell_id[i]),
      .ready_o (cell_rdy[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    launch    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_create || is_start) begin
            state_nxt = ST_DONE;
          end else begin
            launch    = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        load_out = !out_valid_r || !out_stall;
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign chosen_ext = {3'b000, chosen_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      status_r    <= 1'b0;
      count_r     <= '0;
      chosen_r    <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= launch;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (in_accept) begin
        status_r <= is_create && table_full;
        if (is_create && !table_full) begin
          count_r <= count_r + CNTW'(1);
        end
      end
      if (scan_end && chain[SLOTS].found) begin
        chosen_r <= sel_chain[SLOTS];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r.selected_slot  <= chosen_ext[2:0];
      out_word_r.selected_id    <= cell_id[chosen_r];
      out_word_r.selected_ready <= cell_rdy[chosen_r];
      out_word_r.status         <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
